// ===== rtl/aasf_pkg.sv =====
// Package for the angular annulus source filter.
// Holds the CORDIC arctangent table, fixed-point constants and sequencer types.
// No dependencies.
package aasf_pkg;

  localparam logic signed [33:0] OneQ30   = 34'sd1073741824;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic [31:0]        HalfTurn = 32'h8000_0000;
  localparam logic [31:0]        QuarterTurn = 32'h4000_0000;
  localparam int unsigned        TabLen = 40;

  typedef enum logic [1:0] {
    REG_CENTER_RA    = 2'd0,
    REG_CENTER_DEC   = 2'd1,
    REG_INNER_RADIUS = 2'd2,
    REG_OUTER_RADIUS = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS_START,
    ST_COS_RUN,
    ST_COS_DONE,
    ST_MUL1,
    ST_MUL2,
    ST_COMPARE,
    ST_OUT
  } seq_state_e;

  // Cosine job selector, in the order the sequencer runs them.
  typedef enum logic [2:0] {
    JOB_DDEC   = 3'd0,
    JOB_DRA    = 3'd1,
    JOB_DEC    = 3'd2,
    JOB_CDEC   = 3'd3,
    JOB_INNER  = 3'd4,
    JOB_OUTER  = 3'd5
  } cos_job_e;

  function automatic logic [29:0] atan_entry(input logic [5:0] i);
    logic [29:0] t;
    case (i)
      6'd0:  t = 30'd536870912;
      6'd1:  t = 30'd316933406;
      6'd2:  t = 30'd167458907;
      6'd3:  t = 30'd85004756;
      6'd4:  t = 30'd42667331;
      6'd5:  t = 30'd21354465;
      6'd6:  t = 30'd10679838;
      6'd7:  t = 30'd5340245;
      6'd8:  t = 30'd2670163;
      6'd9:  t = 30'd1335087;
      6'd10: t = 30'd667544;
      6'd11: t = 30'd333772;
      6'd12: t = 30'd166886;
      6'd13: t = 30'd83443;
      6'd14: t = 30'd41722;
      6'd15: t = 30'd20861;
      6'd16: t = 30'd10430;
      6'd17: t = 30'd5215;
      6'd18: t = 30'd2608;
      6'd19: t = 30'd1304;
      6'd20: t = 30'd652;
      6'd21: t = 30'd326;
      6'd22: t = 30'd163;
      6'd23: t = 30'd81;
      6'd24: t = 30'd41;
      6'd25: t = 30'd20;
      6'd26: t = 30'd10;
      6'd27: t = 30'd5;
      6'd28: t = 30'd3;
      6'd29: t = 30'd1;
      6'd30: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/angular_annulus_source_filter_core.sv =====
// Top level of the angular annulus source filter: APB registers, sequencer,
// shared CORDIC unit and one 34x34 multiplier. Depends on aasf_pkg, aasf_cordic.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata {dec, ra}, tlast = last_source
//  m_axis   | out | m_axis_tvalid/tready   | tdata {kept_count, dest, index},
//           |     |                        | tuser {window_error, keep}, tlast = eoc
//  apb      | in  | psel/penable/pready    | four 32-bit registers at 0,4,8,12
//
// On the filtering path an item runs from acceptance through six cosines, one
// after another through the single CORDIC unit (each with a start state, a run
// state and a capture state), then two multiplies, a compare and the output
// state; when filtering is off it goes straight to the compare. The sequencer
// returns to idle after the output state before the next word is taken.
// s_axis_tready is high only in idle, so a stalled result word stalls the input.
// The result word is held in the output state until m_axis_tready takes it.
// Reset clears the counters, the sequencer and the registers to their defaults.
module angular_annulus_source_filter_core #(
  parameter int unsigned MAX_SOURCES  = 65536,
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] source_ra, [63:32] source_dec
  input  logic        s_axis_tlast,   // last_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] source_index, [31:16] dest_slot,
                                      // [48:32] kept_count, zero fill above
  output logic [1:0]  m_axis_tuser,   // [0] keep, [1] window_error
  output logic        m_axis_tlast,   // end_of_catalogue
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW = $clog2(MAX_SOURCES + 1);

  logic [31:0] center_ra_q, center_dec_q, inner_q, outer_q;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_ra_q  <= '0;
      center_dec_q <= '0;
      inner_q      <= '0;
      outer_q      <= aasf_pkg::HalfTurn;
    end else if (psel && penable && pwrite) begin
      case (aasf_pkg::reg_idx_e'(reg_idx))
        aasf_pkg::REG_CENTER_RA:    center_ra_q  <= pwdata;
        aasf_pkg::REG_CENTER_DEC:   center_dec_q <= pwdata;
        aasf_pkg::REG_INNER_RADIUS: inner_q      <= pwdata;
        aasf_pkg::REG_OUTER_RADIUS: outer_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (aasf_pkg::reg_idx_e'(reg_idx))
      aasf_pkg::REG_CENTER_RA:    prdata = center_ra_q;
      aasf_pkg::REG_CENTER_DEC:   prdata = center_dec_q;
      aasf_pkg::REG_INNER_RADIUS: prdata = inner_q;
      aasf_pkg::REG_OUTER_RADIUS: prdata = outer_q;
      default:                    prdata = '0;
    endcase
  end

  // Sequencer state
  aasf_pkg::seq_state_e state_q, state_d;
  aasf_pkg::cos_job_e   job_q, job_d;
  logic [31:0] ra_q, dec_q;
  logic        last_q;
  logic [CntW-1:0] in_cnt_q;
  logic [16:0] out_cnt_q;
  logic        keep_q, err_q;
  logic signed [33:0] hd_q, hr_q, cdec_q, ccdec_q, hin_q, hout_q, prod_q, h_q;
  logic signed [67:0] mul_full;
  logic signed [33:0] mul_a, mul_b, mul_rnd;
  logic        bypass;
  logic [31:0] cos_angle;
  logic        cos_start, cos_done;
  logic signed [33:0] cos_val;
  logic signed [34:0] hsum;
  logic        accept_in, take_out, keep_now;

  assign accept_in = s_axis_tvalid && s_axis_tready;
  assign take_out  = m_axis_tvalid && m_axis_tready;
  assign bypass    = (outer_q < inner_q) ||
                     (inner_q == 32'd0 && outer_q >= aasf_pkg::HalfTurn);

  aasf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cos_start),
    .angle_i (cos_angle),
    .done_o  (cos_done),
    .cos_o   (cos_val)
  );

  // Pick the angle for the current cosine job; radii saturate at pi.
  always_comb begin
    case (job_q)
      aasf_pkg::JOB_DDEC:  cos_angle = dec_q - center_dec_q;
      aasf_pkg::JOB_DRA:   cos_angle = ra_q - center_ra_q;
      aasf_pkg::JOB_DEC:   cos_angle = dec_q;
      aasf_pkg::JOB_CDEC:  cos_angle = center_dec_q;
      aasf_pkg::JOB_INNER: cos_angle = (inner_q > aasf_pkg::HalfTurn) ?
                                       aasf_pkg::HalfTurn : inner_q;
      default:             cos_angle = (outer_q > aasf_pkg::HalfTurn) ?
                                       aasf_pkg::HalfTurn : outer_q;
    endcase
  end

  // Shared multiplier, rounded half up by 30 bits.
  assign mul_a    = (state_q == aasf_pkg::ST_MUL1) ? cdec_q : prod_q;
  assign mul_b    = (state_q == aasf_pkg::ST_MUL1) ? ccdec_q : hr_q;
  assign mul_full = mul_a * mul_b;
  assign mul_rnd  = 34'((mul_full + 68'sd536870912) >>> 30);
  assign hsum     = 35'(hd_q) + 35'(mul_rnd);

  // Next state
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      aasf_pkg::ST_IDLE:
        if (accept_in) begin
          state_d = bypass ? aasf_pkg::ST_COMPARE : aasf_pkg::ST_COS_START;
          job_d   = aasf_pkg::JOB_DDEC;
        end
      aasf_pkg::ST_COS_START: state_d = aasf_pkg::ST_COS_RUN;
      aasf_pkg::ST_COS_RUN:   if (cos_done) state_d = aasf_pkg::ST_COS_DONE;
      aasf_pkg::ST_COS_DONE:
        if (job_q == aasf_pkg::JOB_OUTER) begin
          state_d = aasf_pkg::ST_MUL1;
        end else begin
          job_d   = aasf_pkg::cos_job_e'(job_q + 3'd1);
          state_d = aasf_pkg::ST_COS_START;
        end
      aasf_pkg::ST_MUL1:    state_d = aasf_pkg::ST_MUL2;
      aasf_pkg::ST_MUL2:    state_d = aasf_pkg::ST_COMPARE;
      aasf_pkg::ST_COMPARE: state_d = aasf_pkg::ST_OUT;
      aasf_pkg::ST_OUT:     if (take_out) state_d = aasf_pkg::ST_IDLE;
      default:              state_d = aasf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == aasf_pkg::ST_IDLE);
    cos_start     = (state_q == aasf_pkg::ST_COS_START);
    m_axis_tvalid = (state_q == aasf_pkg::ST_OUT);
    keep_now      = err_q || bypass ||
                    (h_q >= hin_q && h_q < hout_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aasf_pkg::ST_IDLE;
      job_q     <= aasf_pkg::JOB_DDEC;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      if (state_q == aasf_pkg::ST_COMPARE && keep_now) out_cnt_q <= out_cnt_q + 1'b1;
      // Advance the input position; clear both counters after the last word or at MAX_SOURCES.
      if (take_out) begin
        if (last_q || (CntW'(in_cnt_q + 1'b1) >= CntW'(MAX_SOURCES))) begin
          in_cnt_q  <= '0;
          out_cnt_q <= '0;
        end else begin
          in_cnt_q <= in_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      ra_q   <= s_axis_tdata[31:0];
      dec_q  <= s_axis_tdata[63:32];
      last_q <= s_axis_tlast;
      err_q  <= outer_q < inner_q;
    end
    if (state_q == aasf_pkg::ST_COS_DONE) begin
      case (job_q)
        aasf_pkg::JOB_DDEC:  hd_q    <= aasf_pkg::OneQ30 - cos_val;
        aasf_pkg::JOB_DRA:   hr_q    <= aasf_pkg::OneQ30 - cos_val;
        aasf_pkg::JOB_DEC:   cdec_q  <= cos_val;
        aasf_pkg::JOB_CDEC:  ccdec_q <= cos_val;
        aasf_pkg::JOB_INNER: hin_q   <= aasf_pkg::OneQ30 - cos_val;
        default:             hout_q  <= aasf_pkg::OneQ30 - cos_val;
      endcase
    end
    if (state_q == aasf_pkg::ST_MUL1) prod_q <= mul_rnd;
    if (state_q == aasf_pkg::ST_MUL2) begin
      if (hsum < 35'sd0)                  h_q <= '0;
      else if (hsum > 35'sd2147483648)    h_q <= 34'sd2147483648;
      else                                h_q <= 34'(hsum);
    end
    if (state_q == aasf_pkg::ST_COMPARE) keep_q <= keep_now;
  end

  // Hold the result word while in the output state.
  logic [16:0] dest_w;
  assign dest_w = keep_q ? (out_cnt_q - 17'd1) : 17'd0;

  assign m_axis_tdata = {7'd0, out_cnt_q, dest_w[15:0], 16'(in_cnt_q)};
  assign m_axis_tuser = {err_q, keep_q};
  assign m_axis_tlast = last_q;

endmodule

// ===== rtl/aasf_cordic.sv =====
// Iterative CORDIC cosine unit for the annulus filter: one rotation step per cycle.
// Depends on aasf_pkg.
module aasf_cordic #(
  parameter int unsigned CORDIC_STEPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o
);

  localparam int unsigned StepW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic               neg_q, neg_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic signed [33:0] dx, dy, tab, xs;
  logic [31:0]        r;
  logic [5:0]         idx;

  always_comb begin
    idx = 6'(step_q);
    dx  = y_q >>> step_q;
    dy  = x_q >>> step_q;
    tab = {4'd0, aasf_pkg::atan_entry(idx)};
    r   = angle_i;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      neg_d = 1'b0;
      if (((angle_i + aasf_pkg::QuarterTurn) & aasf_pkg::HalfTurn) != 32'd0) begin
        r     = angle_i - aasf_pkg::HalfTurn;
        neg_d = 1'b1;
      end
      x_d    = aasf_pkg::CordicX0;
      y_d    = '0;
      z_d    = 34'(signed'(r));
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - tab;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + tab;
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    xs = x_q;
    if (xs > aasf_pkg::OneQ30) xs = aasf_pkg::OneQ30;
    if (xs < -aasf_pkg::OneQ30) xs = -aasf_pkg::OneQ30;
    cos_o = neg_q ? -xs : xs;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for angular_annulus_source_filter_core: drives sources on
// the input stream, predicts each result word with a CORDIC haversine model.
// Depends on aasf_pkg and the core RTL.
module tb_top;

  localparam int unsigned MaxSources  = 65536;
  localparam int unsigned CordicSteps = 32;
  localparam int unsigned ItemCycles  = 6 * (CordicSteps + 3) + 5;
  localparam longint      CycleLimit  = 3000000;

  typedef struct packed {
    logic        last;
    logic [31:0] dec;
    logic [31:0] ra;
  } source_t;

  typedef struct packed {
    logic        keep;
    logic [15:0] index;
    logic [15:0] slot;
    logic [16:0] kept;
    logic        werr;
    logic        eoc;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] source_ra, [63:32] source_dec
  logic        s_axis_tlast = 1'b0; // last_source
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [15:0] index, [31:16] slot, [48:32] kept_count
  logic [1:0]  m_axis_tuser;        // [0] keep, [1] window_error
  logic        m_axis_tlast;        // end_of_catalogue
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  angular_annulus_source_filter_core #(
    .MAX_SOURCES(MaxSources), .CORDIC_STEPS(CordicSteps)
  ) dut (.*);

  always #2 clk_i = ~clk_i;

  // Model state: window registers and catalogue counters.
  logic [31:0] win_ra, win_dec, win_inner, win_outer;
  int unsigned seen_cnt, kept_cnt;

  source_t  pending_sources[$];
  verdict_t expected_verdicts[$];
  int       fail_cnt = 0;
  longint   cycle_cnt = 0;
  bit       hold_off = 1'b0;

  // CORDIC cosine in Q2.30, saturated to +-1.
  function automatic longint cos_q30(logic [31:0] a);
    logic [31:0] r;
    bit          neg;
    longint      x, y, z, dx, dy, c;
    r = a;
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (((a + aasf_pkg::QuarterTurn) & aasf_pkg::HalfTurn) != 0) begin
      r = a - aasf_pkg::HalfTurn;
      neg = 1'b1;
    end
    z = longint'($signed(r));
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(aasf_pkg::atan_entry(i[5:0]));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(aasf_pkg::atan_entry(i[5:0]));
      end
    end
    c = x;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    if (c < -64'sd1073741824) c = -64'sd1073741824;
    return neg ? -c : c;
  endfunction

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint radius_hav(logic [31:0] r);
    if (r > aasf_pkg::HalfTurn) r = aasf_pkg::HalfTurn;
    return 64'sd1073741824 - cos_q30(r);
  endfunction

  // Work out the result for one source and advance the counters.
  function automatic verdict_t filter_source(source_t s);
    verdict_t v;
    longint   hd, hr, p, h;
    v = '0;
    v.werr = win_outer < win_inner;
    if (v.werr || (win_inner == 0 && win_outer >= aasf_pkg::HalfTurn)) begin
      v.keep = 1'b1;
    end else begin
      hd = 64'sd1073741824 - cos_q30(s.dec - win_dec);
      hr = 64'sd1073741824 - cos_q30(s.ra - win_ra);
      p = round_q30(cos_q30(s.dec) * cos_q30(win_dec));
      h = hd + round_q30(p * hr);
      if (h < 0) h = 0;
      if (h > 64'sd2147483648) h = 64'sd2147483648;
      v.keep = (h >= radius_hav(win_inner)) && (h < radius_hav(win_outer));
    end
    v.index = seen_cnt[15:0];
    if (v.keep) begin
      v.slot = kept_cnt[15:0];
      kept_cnt++;
    end
    v.kept = kept_cnt[16:0];
    v.eoc = s.last;
    seen_cnt++;
    if (s.last || seen_cnt >= MaxSources) begin
      seen_cnt = 0;
      kept_cnt = 0;
    end
    return v;
  endfunction

  // Driver: bursts with random gaps; advance on each accepted word.
  int gap_left = 0, burst_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.push_back(filter_source(pending_sources.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word
      end else if (pending_sources.size() > 0 && gap_left == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_sources[0].dec, pending_sources[0].ra};
        s_axis_tlast  <= pending_sources[0].last;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 60);
      end else begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver stall pattern: alternate ready and stalled runs of random length.
  int stall_run = 0;
  bit stall_phase = 1'b0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_phase = ~stall_phase;
      stall_run = ($urandom_range(0, 3) == 0) ? 400 : $urandom_range(1, 90);
    end
    stall_run--;
    m_axis_tready <= !hold_off && (stall_phase || $urandom_range(0, 7) == 0);
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    cycle_cnt++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result word with nothing expected: tdata=%h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (m_axis_tuser[0] !== exp_v.keep) begin
          $error("keep: expected %0d actual %0d", exp_v.keep, m_axis_tuser[0]);
          fail_cnt++;
        end
        if (m_axis_tdata[15:0] !== exp_v.index) begin
          $error("source_index: expected %0d actual %0d", exp_v.index, m_axis_tdata[15:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[31:16] !== exp_v.slot) begin
          $error("dest_slot: expected %0d actual %0d", exp_v.slot, m_axis_tdata[31:16]);
          fail_cnt++;
        end
        if (m_axis_tdata[48:32] !== exp_v.kept) begin
          $error("kept_count: expected %0d actual %0d", exp_v.kept, m_axis_tdata[48:32]);
          fail_cnt++;
        end
        if (m_axis_tuser[1] !== exp_v.werr) begin
          $error("window_error: expected %0d actual %0d", exp_v.werr, m_axis_tuser[1]);
          fail_cnt++;
        end
        if (m_axis_tlast !== exp_v.eoc) begin
          $error("end_of_catalogue: expected %0d actual %0d", exp_v.eoc, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(aasf_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      aasf_pkg::REG_CENTER_RA:    win_ra = value;
      aasf_pkg::REG_CENTER_DEC:   win_dec = value;
      aasf_pkg::REG_INNER_RADIUS: win_inner = value;
      default:                    win_outer = value;
    endcase
  endtask

  // Drain all expectations, then let the sequencer settle before a write.
  task automatic drain;
    wait (pending_sources.size() == 0 && expected_verdicts.size() == 0);
    repeat (ItemCycles + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_dec();
    case ($urandom_range(0, 5))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    endcase
  endfunction

  // Queue a catalogue of sources, mostly near the centre so the annulus test bites.
  task automatic queue_catalogue(int count);
    source_t s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        s.ra  = win_ra + ($urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
        s.dec = win_dec + ($urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
      end else begin
        s.ra  = $urandom;
        s.dec = pick_dec();
      end
      s.last = (i == count - 1) || ($urandom_range(0, 40) == 0);
      pending_sources.push_back(s);
    end
  endtask

  initial begin
    logic [31:0] edge_vals[6];
    source_t s;
    edge_vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                  32'hC000_0000, 32'h0000_0001};
    win_ra = 0; win_dec = 0; win_inner = 0; win_outer = aasf_pkg::HalfTurn;
    seen_cnt = 0; kept_cnt = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unfiltered at reset defaults: field extremes.
    for (int i = 0; i < 6; i++) begin
      s.ra = edge_vals[i]; s.dec = edge_vals[5 - i]; s.last = (i == 5);
      pending_sources.push_back(s);
    end
    drain();
    // Annulus around an off-axis centre, including sources exactly at the centre.
    write_reg(aasf_pkg::REG_CENTER_RA, 32'h2000_0000);
    write_reg(aasf_pkg::REG_CENTER_DEC, 32'hE000_0000);
    write_reg(aasf_pkg::REG_INNER_RADIUS, 32'h0100_0000);
    write_reg(aasf_pkg::REG_OUTER_RADIUS, 32'h0800_0000);
    for (int i = 0; i < 8; i++) begin
      s.ra = 32'h2000_0000 + i * 32'h0080_0000; s.dec = 32'hE000_0000;
      s.last = (i == 7);
      pending_sources.push_back(s);
    end
    drain();
    // Bad window, then radii beyond pi.
    write_reg(aasf_pkg::REG_INNER_RADIUS, 32'h0800_0000);
    write_reg(aasf_pkg::REG_OUTER_RADIUS, 32'h0100_0000);
    queue_catalogue(5);
    drain();
    write_reg(aasf_pkg::REG_INNER_RADIUS, 32'hFFFF_FFFF);
    write_reg(aasf_pkg::REG_OUTER_RADIUS, 32'hFFFF_FFFF);
    queue_catalogue(4);
    drain();

    // Random phases over several windows; one long receiver hold-off.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(aasf_pkg::REG_CENTER_RA, $urandom);
      write_reg(aasf_pkg::REG_CENTER_DEC, pick_dec());
      case (ph % 4)
        0: begin
          write_reg(aasf_pkg::REG_INNER_RADIUS, 32'd0);
          write_reg(aasf_pkg::REG_OUTER_RADIUS, $urandom_range(0, 32'h1000_0000));
        end
        1: begin
          write_reg(aasf_pkg::REG_INNER_RADIUS, $urandom_range(0, 32'h0400_0000));
          write_reg(aasf_pkg::REG_OUTER_RADIUS,
                    $urandom_range(32'h0400_0000, 32'h8000_0000));
        end
        2: begin
          write_reg(aasf_pkg::REG_INNER_RADIUS, $urandom_range(0, 32'h8000_0000));
          write_reg(aasf_pkg::REG_OUTER_RADIUS, $urandom);
        end
        default: begin
          write_reg(aasf_pkg::REG_INNER_RADIUS, $urandom_range(0, 32'h0200_0000));
          write_reg(aasf_pkg::REG_OUTER_RADIUS, 32'h8000_0000);
        end
      endcase
      if (ph == 3) hold_off = 1'b1;
      queue_catalogue(160);
      if (ph == 3) begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    repeat (ItemCycles) @(posedge clk_i);
    if (fail_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
